FILE: hdl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package uer_pkg;

    localparam int CNT_W  = 13;
    localparam int DIST_W = 12;
    localparam int STAT_W = 2;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 13;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_ECHO  = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_TRIGGER_WIDTH    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_SETTLE_TIME      = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_START_TIMEOUT    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_BLANK_TIME       = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_END_TIMEOUT      = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_TIMEOUT_DISTANCE = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_NO_ECHO_HOLDOFF  = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_DONE_HOLDOFF     = 3'd7;

    typedef struct packed {
        logic [7:0]  trigger_width;
        logic [9:0]  settle_time;
        logic [12:0] start_timeout;
        logic [9:0]  blank_time;
        logic [12:0] end_timeout;
        logic [7:0]  timeout_distance;
        logic [9:0]  no_echo_holdoff;
        logic [9:0]  done_holdoff;
    } t_cfg;

    typedef struct packed {
        logic              trigger_out;
        logic              busy_res;
        logic              done_res;
        logic [DIST_W-1:0] distance;
        logic [STAT_W-1:0] status;
    } t_res;

    function automatic logic [CNT_W-1:0] cnt_sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
    endfunction

endpackage

FILE: hdl/uer_scale.sv
// Distance scaling: echo ticks to 1/16 cm by reciprocal multiply, and the
// shifted timeout distance, both saturated. Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_scale #(
    parameter int FRACTION_BITS = 4
) (
    input  logic [uer_pkg::CNT_W-1:0]  i_elapsed,
    input  logic [7:0]                 i_timeout_distance,
    output logic [uer_pkg::DIST_W-1:0] o_echo_dist,
    output logic [uer_pkg::DIST_W-1:0] o_long_dist
);
    import uer_pkg::*;

    // x = elapsed << FRACTION_BITS; floor(x / 58) = (x * MUL) >> SH exactly,
    // since the rounding error of MUL times x stays below 2^SH.
    localparam int    XW  = CNT_W + FRACTION_BITS;
    localparam int    SH  = XW + 6;
    localparam int    MW  = SH - 5;
    localparam int    PW  = XW + MW;
    localparam int    QW  = PW - SH;
    localparam longint MUL = ((longint'(1) << SH) + 57) / 58;
    localparam int    TW  = 8 + FRACTION_BITS;

    logic [XW-1:0]        w_x;
    logic [PW-1:0]        w_prod;
    logic [QW-1:0]        w_q;
    logic [QW+DIST_W-1:0] w_qx;
    logic [TW-1:0]        w_t;
    logic [TW+DIST_W-1:0] w_tx;

    assign w_x    = XW'(i_elapsed) << FRACTION_BITS;
    assign w_prod = PW'(w_x) * PW'(MUL);
    assign w_q    = w_prod[PW-1:SH];
    assign w_qx   = (QW+DIST_W)'(w_q);

    assign w_t    = TW'(i_timeout_distance) << FRACTION_BITS;
    assign w_tx   = (TW+DIST_W)'(w_t);

    assign o_echo_dist = (w_qx > (QW+DIST_W)'(DIST_MAX)) ? DIST_MAX : w_qx[DIST_W-1:0];
    assign o_long_dist = (w_tx > (TW+DIST_W)'(DIST_MAX)) ? DIST_MAX : w_tx[DIST_W-1:0];

endmodule

FILE: hdl/uer_fsm.sv
// Ranging sequencer: phase register, tick and elapsed counters, and the
// result of the current tick. Depends on uer_pkg and uer_scale.
`timescale 1ns / 1ps

module uer_fsm #(
    parameter int FRACTION_BITS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic          i_start,
    input  logic          i_echo,
    input  uer_pkg::t_cfg i_cfg,
    output uer_pkg::t_res o_res
);
    import uer_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_TRIG    = 3'd1;
    localparam logic [2:0] PH_SETTLE  = 3'd2;
    localparam logic [2:0] PH_WAIT    = 3'd3;
    localparam logic [2:0] PH_BLANK   = 3'd4;
    localparam logic [2:0] PH_MEASURE = 3'd5;
    localparam logic [2:0] PH_HOLD    = 3'd6;

    logic [2:0]       r_phase,   n_phase;
    logic [CNT_W-1:0] r_tick,    n_tick;
    logic [CNT_W-1:0] r_elapsed, n_elapsed;
    logic             r_long,    n_long;

    logic [DIST_W-1:0] w_echo_dist, w_long_dist;
    logic [CNT_W-1:0]  w_tick_inc, w_elap_inc;
    logic [2:0]        w_after_trig;

    uer_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale (
        .i_elapsed          (r_elapsed),
        .i_timeout_distance (i_cfg.timeout_distance),
        .o_echo_dist        (w_echo_dist),
        .o_long_dist        (w_long_dist)
    );

    assign w_tick_inc   = cnt_sat_inc(r_tick);
    assign w_elap_inc   = cnt_sat_inc(r_elapsed);
    assign w_after_trig = (i_cfg.settle_time == 10'd0) ? PH_WAIT : PH_SETTLE;

    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_elapsed = r_elapsed;
        n_long    = r_long;
        o_res     = '0;
        o_res.busy_res = 1'b1;

        unique case (r_phase)
            PH_IDLE: begin
                o_res.busy_res = 1'b0;
                if (i_start) begin
                    o_res.busy_res    = 1'b1;
                    o_res.trigger_out = 1'b1;
                    if (i_cfg.trigger_width <= 8'd1) begin
                        n_tick  = '0;
                        n_phase = w_after_trig;
                    end else begin
                        n_tick  = CNT_W'(1);
                        n_phase = PH_TRIG;
                    end
                end
            end
            PH_TRIG: begin
                o_res.trigger_out = 1'b1;
                n_tick = w_tick_inc;
                if (w_tick_inc >= CNT_W'(i_cfg.trigger_width)) begin
                    n_tick  = '0;
                    n_phase = w_after_trig;
                end
            end
            PH_SETTLE: begin
                n_tick = w_tick_inc;
                if (w_tick_inc >= CNT_W'(i_cfg.settle_time)) begin
                    n_tick  = '0;
                    n_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (i_echo) begin
                    n_elapsed = '0;
                    n_phase   = (i_cfg.blank_time == 10'd0) ? PH_MEASURE : PH_BLANK;
                end else begin
                    n_tick = w_tick_inc;
                    if (w_tick_inc >= i_cfg.start_timeout) begin
                        o_res.done_res = 1'b1;
                        o_res.status   = ST_NO_ECHO;
                        n_long  = 1'b1;
                        n_tick  = '0;
                        n_phase = (i_cfg.no_echo_holdoff == 10'd0) ? PH_IDLE : PH_HOLD;
                    end
                end
            end
            PH_BLANK: begin
                n_elapsed = w_elap_inc;
                if (w_elap_inc >= CNT_W'(i_cfg.blank_time)) begin
                    n_phase = PH_MEASURE;
                end
            end
            PH_MEASURE: begin
                if (!i_echo) begin
                    o_res.done_res = 1'b1;
                    o_res.status   = ST_OK;
                    o_res.distance = w_echo_dist;
                    n_long  = 1'b0;
                    n_tick  = '0;
                    n_phase = (i_cfg.done_holdoff == 10'd0) ? PH_IDLE : PH_HOLD;
                end else begin
                    n_elapsed = w_elap_inc;
                    if (w_elap_inc >= i_cfg.end_timeout) begin
                        o_res.done_res = 1'b1;
                        o_res.status   = ST_TOO_LONG;
                        o_res.distance = w_long_dist;
                        n_long  = 1'b0;
                        n_tick  = '0;
                        n_phase = (i_cfg.done_holdoff == 10'd0) ? PH_IDLE : PH_HOLD;
                    end
                end
            end
            PH_HOLD: begin
                n_tick = w_tick_inc;
                if (w_tick_inc >= CNT_W'(r_long ? i_cfg.no_echo_holdoff
                                                : i_cfg.done_holdoff)) begin
                    n_tick  = '0;
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                o_res.busy_res = 1'b0;
                n_tick  = '0;
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_elapsed <= '0;
            r_long    <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_elapsed <= n_elapsed;
            r_long    <= n_long;
        end
    end

endmodule

FILE: hdl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: configuration registers, input
// and result registers around the sequencer. Depends on uer_pkg, uer_fsm.
`timescale 1ns / 1ps

// Usage
//   Feed one item per microsecond tick on the slave stream: tdata[0] is the
//   start request, tdata[1] the sampled echo pin level. Every accepted item
//   yields exactly one result item on the master stream: trigger level,
//   busy, done, distance in 1/16 cm (tdata) and status (tuser: ok, no echo,
//   echo too long). Distance and status are zero unless done is set.
//   An accepted item passes through the input register, then the result
//   register, before it is offered. Throughput: one item per clock while
//   the receiver keeps tready high, set by the single sequencer step and
//   one reciprocal multiply that sit between the two registers.
//   Stalls: while the receiver holds tready low the result register holds
//   its item and the input register can still take one more item; after
//   that tready on the slave side drops until the result is taken.
//   Configuration is written through the plain write port while idle.
//   Reset (synchronous, active low) empties both registers, returns the
//   sequencer to idle with cleared counters and loads the register defaults.
module ultrasonic_echo_ranger #(
    parameter int FRACTION_BITS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic [uer_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [uer_pkg::CFG_DW-1:0] i_cfg_data,
    // tick stream in
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [7:0]                 i_s_axis_tdata,  // [0] start_req, [1] echo_level
    // result stream out
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [15:0]                o_m_axis_tdata,  // [0] trigger_out, [1] busy_res,
                                                        // [2] done_res, [14:3] distance
    output logic [1:0]                 o_m_axis_tuser   // [1:0] status
);
    import uer_pkg::*;

    t_cfg r_cfg;
    t_res r_res;
    t_res w_res;

    logic r_in_valid;
    logic r_in_start;
    logic r_in_echo;
    logic r_out_valid;
    logic w_accept;
    logic w_adv;

    // Move the held item into the result register when that register is
    // free or is being emptied this cycle.
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_width    <= 8'd10;
            r_cfg.settle_time      <= 10'd240;
            r_cfg.start_timeout    <= 13'd3000;
            r_cfg.blank_time       <= 10'd60;
            r_cfg.end_timeout      <= 13'd7000;
            r_cfg.timeout_distance <= 8'd120;
            r_cfg.no_echo_holdoff  <= 10'd100;
            r_cfg.done_holdoff     <= 10'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TRIGGER_WIDTH:    r_cfg.trigger_width    <= i_cfg_data[7:0];
                CFG_SETTLE_TIME:      r_cfg.settle_time      <= i_cfg_data[9:0];
                CFG_START_TIMEOUT:    r_cfg.start_timeout    <= i_cfg_data[12:0];
                CFG_BLANK_TIME:       r_cfg.blank_time       <= i_cfg_data[9:0];
                CFG_END_TIMEOUT:      r_cfg.end_timeout      <= i_cfg_data[12:0];
                CFG_TIMEOUT_DISTANCE: r_cfg.timeout_distance <= i_cfg_data[7:0];
                CFG_NO_ECHO_HOLDOFF:  r_cfg.no_echo_holdoff  <= i_cfg_data[9:0];
                CFG_DONE_HOLDOFF:     r_cfg.done_holdoff     <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Input register: hold the tick item until the sequencer steps on it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_start <= i_s_axis_tdata[0];
            r_in_echo  <= i_s_axis_tdata[1];
        end
    end

    // Sequencer advances exactly once per item moved to the result register
    uer_fsm #(.FRACTION_BITS(FRACTION_BITS)) u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_start (r_in_start),
        .i_echo  (r_in_echo),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // Result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_res.distance, r_res.done_res,
                              r_res.busy_res, r_res.trigger_out};
    assign o_m_axis_tuser  = r_res.status;

    // Checks on the block's own logic
    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while both registers are full and stalled");

    a_idle_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.done_res) |-> (r_res.distance == '0 && r_res.status == ST_OK))
        else $error("distance or status set without done");

    a_no_echo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.status == ST_NO_ECHO) |-> (r_res.distance == '0))
        else $error("no-echo result carries a distance");

    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.trigger_out || r_res.done_res)) |-> r_res.busy_res)
        else $error("trigger or done reported while not busy");

endmodule
